/* rtl/core/lgs_pkg.sv */
// Shared types and constants for the life grid generation step block.
// Request/response word layouts, register codes and sweep control bundle.
// No dependencies.
`default_nettype none

package lgs_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 128;

  localparam int CNT_W = 13;
  localparam int RUN_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // configuration register indexes
  localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] CFG_COL_COUNT    = 2'd1;
  localparam logic [1:0] CFG_REPEAT_LIMIT = 2'd2;

  localparam logic [5:0]       ROW_COUNT_RST    = 6'd23;
  localparam logic [7:0]       COL_COUNT_RST    = 8'd80;
  localparam logic [RUN_W-1:0] REPEAT_LIMIT_RST = '0;

  // request types
  localparam logic [1:0] REQ_TOGGLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_STEP   = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } req_word_t;

  typedef struct packed {
    logic             cell_value;
    logic [CNT_W-1:0] births;
    logic [CNT_W-1:0] deaths;
    logic [CNT_W-1:0] change_total;
    logic [RUN_W-1:0] balanced_run;
    logic             stop;
  } rsp_word_t;

  // sweep control from the sequencer to the window datapath
  typedef struct packed {
    logic clr_counts;
    logic load_prime;
    logic load_below;
    logic below_ok;
    logic clr_prev;
    logic advance;
    logic shift;
    logic col_ok;
    logic right_ok;
  } win_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/lgs_row_mem.sv */
// Grid storage: one word per grid row, one write and one registered read per cycle.
// Per-row valid bits make never-written rows read as all dead after reset.
// Standalone, no package use.
`default_nettype none

module lgs_row_mem #(
  parameter int ROWS = 32,
  parameter int COLS = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [$clog2(ROWS)-1:0] wr_addr,
  input  logic [COLS-1:0]         wr_data,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  output logic [COLS-1:0]         rd_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= row_vld[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (wr_en) begin
      row_vld[wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lgs_window.sv */
// Sweep datapath: three rotating row shift registers feed a 3x3 window,
// one cell per cycle while ctl.shift is set; applies B3/S23 and counts births and deaths.
// Depends on lgs_pkg.
`default_nettype none

module lgs_window #(
  parameter int COLS = 128
) (
  input  logic                           clk,
  input  lgs_pkg::win_ctl_t              ctl,
  input  logic [COLS-1:0]                rd_data,
  output logic [COLS-1:0]                new_row,
  output logic [lgs_pkg::CNT_W-1:0]      births,
  output logic [lgs_pkg::CNT_W-1:0]      deaths
);
  import lgs_pkg::*;

  logic [COLS-1:0] above;
  logic [COLS-1:0] cur;
  logic [COLS-1:0] below;
  logic [2:0]      prev;   // column c-1 of above, cur, below
  logic [3:0]      nsum;
  logic            nxt;
  logic            born;
  logic            died;

  always_comb begin
    nsum = 4'(prev[2]) + 4'(prev[1]) + 4'(prev[0]) + 4'(above[0]) + 4'(below[0]);
    if (ctl.right_ok) begin
      nsum = nsum + 4'(above[1]) + 4'(cur[1]) + 4'(below[1]);
    end
    if (ctl.col_ok) begin
      nxt = (nsum == 4'd3) || ((nsum == 4'd2) && cur[0]);
    end else begin
      nxt = cur[0];   // columns past the grid keep their bits
    end
    born = nxt && !cur[0];
    died = !nxt && cur[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prime) begin
      above <= '0;
      cur   <= rd_data;
    end
    if (ctl.load_below) begin
      below <= ctl.below_ok ? rd_data : '0;
    end
    if (ctl.advance) begin
      above <= cur;
      cur   <= below;
    end
    if (ctl.clr_prev) begin
      prev <= '0;
    end
    if (ctl.shift) begin
      // rotate so each row is intact again after a full sweep
      above   <= {above[0], above[COLS-1:1]};
      cur     <= {cur[0], cur[COLS-1:1]};
      below   <= {below[0], below[COLS-1:1]};
      new_row <= {nxt, new_row[COLS-1:1]};
      prev    <= {above[0], cur[0], below[0]};
      if (born && births != CNT_MAX) begin
        births <= births + 1'b1;
      end
      if (died && deaths != CNT_MAX) begin
        deaths <= deaths + 1'b1;
      end
    end
    if (ctl.clr_counts) begin
      births <= '0;
      deaths <= '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/life_grid_generation_step.sv */
// Life grid (B3/S23) with toggle, read and whole-grid step requests, one at a time.
// Toggle/read: the row is read, the cell read or flipped, then the word sent; a cell outside
// the grid or an unused type skips to the word. Step: S_PRIME, S_PRIME2, then per row in use
// S_LOADB, the one-cell-per-cycle window sweep over every column (S_SWEEP) and S_WRITE, then
// S_BAL, S_FIN (an empty grid skips to S_BAL). A request is taken once the word is valid; a
// stalled word holds the next one. Reset (rst, sync) clears the grid via per-row valid bits.
`default_nettype none

module life_grid_generation_step #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               req_valid,
  output logic               req_stall,
  input  lgs_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output lgs_pkg::rsp_word_t rsp
);
  import lgs_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int NR_W  = $clog2(MAX_ROWS + 1);
  localparam int NC_W  = $clog2(MAX_COLS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_COP, S_PRIME, S_PRIME2, S_LOADB, S_SWEEP, S_WRITE, S_BAL, S_FIN
  } state_t;

  state_t state;

  logic [5:0]       row_count;
  logic [7:0]       col_count;
  logic [RUN_W-1:0] repeat_limit;

  logic [NR_W-1:0]  nr;
  logic [NC_W-1:0]  nc;
  logic             req_fire;
  logic             in_range;

  logic [1:0]       req_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] col;

  logic             res_value;
  logic [CNT_W-1:0] res_born;
  logic [CNT_W-1:0] res_died;
  logic             res_stop;
  logic [RUN_W-1:0] bal_cnt;
  logic [RUN_W-1:0] bal_next;
  logic [CNT_W:0]   chg_sum;
  logic [CNT_W-1:0] chg_total;

  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;
  logic [MAX_COLS-1:0] wr_data;
  logic [ROW_W-1:0] rd_addr;
  logic [MAX_COLS-1:0] rd_data;
  logic [MAX_COLS-1:0] new_row;
  logic [CNT_W-1:0] win_births;
  logic [CNT_W-1:0] win_deaths;
  win_ctl_t         ctl;
  logic             last_row;
  logic             cell_bit;

  assign nr = (32'(row_count) > MAX_ROWS) ? NR_W'(MAX_ROWS) : NR_W'(row_count);
  assign nc = (32'(col_count) > MAX_COLS) ? NC_W'(MAX_COLS) : NC_W'(col_count);

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign in_range  = (32'(req.cell_row) < 32'(nr)) && (32'(req.cell_col) < 32'(nc));
  assign last_row  = (NR_W'(r) + NR_W'(1)) == nr;
  assign cell_bit  = rd_data[col_q];

  assign bal_next = (win_births == win_deaths)
                  ? ((bal_cnt == RUN_MAX) ? RUN_MAX : bal_cnt + 1'b1)
                  : '0;
  assign chg_sum   = (CNT_W+1)'(res_born) + (CNT_W+1)'(res_died);
  assign chg_total = (chg_sum > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : chg_sum[CNT_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RST;
      col_count    <= COL_COUNT_RST;
      repeat_limit <= REPEAT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ROW_COUNT:    row_count    <= cfg_wdata[5:0];
        CFG_COL_COUNT:    col_count    <= cfg_wdata[7:0];
        CFG_REPEAT_LIMIT: repeat_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // memory port and sweep control
  always_comb begin
    case (state)
      S_CRD:    rd_addr = row_q;
      S_PRIME:  rd_addr = '0;
      S_PRIME2: rd_addr = ROW_W'(1);
      S_WRITE:  rd_addr = ROW_W'(32'(r) + 2);
      default:  rd_addr = row_q;
    endcase

    wr_en   = (state == S_WRITE) || ((state == S_COP) && (req_q == REQ_TOGGLE));
    wr_addr = (state == S_WRITE) ? r : row_q;
    wr_data = (state == S_WRITE) ? new_row
                                 : (rd_data ^ (MAX_COLS'(1) << col_q));

    ctl.clr_counts = req_fire && (req.req_type == REQ_STEP);
    ctl.load_prime = (state == S_PRIME2);
    ctl.load_below = (state == S_LOADB);
    ctl.below_ok   = (NR_W'(r) + NR_W'(1)) < nr;
    ctl.clr_prev   = (state == S_LOADB);
    ctl.advance    = (state == S_WRITE);
    ctl.shift      = (state == S_SWEEP);
    ctl.col_ok     = NC_W'(col) < nc;
    ctl.right_ok   = (NC_W'(col) + NC_W'(1)) < nc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      bal_cnt   <= '0;
    end else begin
      // S_FIN presents the next word itself
      if (rsp_valid && !rsp_stall && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            req_q     <= req.req_type;
            row_q     <= ROW_W'(req.cell_row);
            col_q     <= COL_W'(req.cell_col);
            res_value <= 1'b0;
            res_born  <= '0;
            res_died  <= '0;
            res_stop  <= 1'b0;
            case (req.req_type)
              REQ_TOGGLE, REQ_READ: state <= in_range ? S_CRD : S_FIN;
              REQ_STEP: state <= ((nr == '0) || (nc == '0)) ? S_BAL : S_PRIME;
              default:  state <= S_FIN;
            endcase
          end
        end
        S_CRD: state <= S_COP;
        S_COP: begin
          if (req_q == REQ_TOGGLE) begin
            res_value <= !cell_bit;
            res_born  <= CNT_W'(!cell_bit);
            res_died  <= CNT_W'(cell_bit);
          end else begin
            res_value <= cell_bit;
          end
          state <= S_FIN;
        end
        S_PRIME: state <= S_PRIME2;
        S_PRIME2: begin
          r     <= '0;
          state <= S_LOADB;
        end
        S_LOADB: begin
          col   <= '0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          col <= col + 1'b1;
          if (col == COL_W'(MAX_COLS - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          r     <= r + 1'b1;
          state <= last_row ? S_BAL : S_LOADB;
        end
        S_BAL: begin
          res_born <= win_births;
          res_died <= win_deaths;
          bal_cnt  <= bal_next;
          res_stop <= (repeat_limit != '0) && (bal_next == repeat_limit);
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.cell_value   <= res_value;
            rsp.births       <= res_born;
            rsp.deaths       <= res_died;
            rsp.change_total <= chg_total;
            rsp.balanced_run <= bal_cnt;
            rsp.stop         <= res_stop;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lgs_row_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgs_window #(
    .COLS (MAX_COLS)
  ) u_win (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data),
    .new_row (new_row),
    .births  (win_births),
    .deaths  (win_deaths)
  );

endmodule

`default_nettype wire
